// ----- design/pams_pkg.sv -----
// ----------------------------------------------------------------------------
// pams_pkg
// Shared types and constants of the paced A/V mux scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pams_pkg;

  localparam int unsigned VIDEO_DEPTH_DEF = 8;
  localparam int unsigned AUDIO_DEPTH_DEF = 32;

  localparam int unsigned PTS_W    = 48;
  localparam int unsigned P90K_W   = 45;
  localparam int unsigned THR_W    = 32;
  localparam int unsigned PROD_W   = PTS_W + 4;  // pts * 9
  localparam int unsigned DIVISOR  = 100;

  // op codes
  localparam logic [1:0] OP_VIDEO = 2'd0;
  localparam logic [1:0] OP_AUDIO = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  // register indexes
  localparam logic REG_PACING = 1'b0;
  localparam logic REG_THRESH = 1'b1;

  localparam logic [THR_W-1:0] THRESH_RST = THR_W'(1000000);

  typedef struct packed {
    logic [1:0]       op;
    logic [PTS_W-1:0] pts;
    logic             pad;
    logic [PTS_W-1:0] now;
  } cmd_t;

  typedef struct packed {
    logic              kind;
    logic [P90K_W-1:0] pts_90k;
    logic              is_real;
    logic              takeover;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

// ----- design/pams_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// pams_cmd_queue
// Front end: takes commands, drops the NOP op code, two-entry queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pams_cmd_queue import pams_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire cmd_t cmd_i,
  output logic      full_o,
  output logic      valid_o,
  output cmd_t      cmd_o,
  input  wire logic pop_i
);

  cmd_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = mem_q[rptr_q];
  assign push    = start_i && !full_o && (cmd_i.op != OP_NOP);

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop_i);
    end
  end

endmodule

`default_nettype wire

// ----- design/pams_div.sv -----
// ----------------------------------------------------------------------------
// pams_div
// Divide by 100 in four 13-bit digit steps, each by reciprocal multiplication.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pams_div import pams_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [PROD_W-1:0] value_i,
  output logic                   done_o,
  output logic [P90K_W-1:0]      quot_o
);

  localparam int unsigned DIG_W    = 13;
  localparam int unsigned STEPS    = PROD_W / DIG_W;
  localparam int unsigned CW       = $clog2(STEPS + 1);
  localparam int unsigned REM_W    = 7;
  localparam int unsigned CHUNK_W  = REM_W + DIG_W;
  localparam int unsigned RECIP_W  = 21;
  localparam int unsigned RECIP_SH = 27;
  localparam int unsigned MUL_W    = CHUNK_W + RECIP_W;
  // ceil(2^27 / 100); exact for every chunk below 100 * 2^13
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(1342178);

  logic [PROD_W-1:0]  sh_q;
  logic [REM_W-1:0]   rem_q;
  logic [CW-1:0]      cnt_q;
  logic               done_q;
  logic [CHUNK_W-1:0] chunk;
  logic [MUL_W-1:0]   prod;
  logic [DIG_W-1:0]   qdig;
  logic [CHUNK_W-1:0] back;
  logic [CHUNK_W-1:0] rem_full;

  assign chunk    = {rem_q, sh_q[PROD_W-1 -: DIG_W]};
  assign prod     = MUL_W'(chunk) * MUL_W'(RECIP);
  assign qdig     = prod[RECIP_SH +: DIG_W];
  assign back     = CHUNK_W'(qdig) * CHUNK_W'(DIVISOR);
  assign rem_full = chunk - back;
  assign done_o   = done_q;
  assign quot_o   = sh_q[P90K_W-1:0];

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= value_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      // quotient digits shift in as dividend digits shift out
      sh_q  <= {sh_q[PROD_W-DIG_W-1:0], qdig};
      rem_q <= rem_full[REM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CW'(1));
      if (start_i) cnt_q <= CW'(STEPS);
      else if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- design/pams_engine.sv -----
// ----------------------------------------------------------------------------
// pams_engine
// Back end: frame queues, pacing decision and release sequencing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pams_engine import pams_pkg::*; #(
  parameter int unsigned VIDEO_DEPTH = VIDEO_DEPTH_DEF,
  parameter int unsigned AUDIO_DEPTH = AUDIO_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cmd_valid_i,
  input  wire cmd_t             cmd_i,
  output logic                  cmd_pop_o,
  input  wire logic             pacing_en_i,
  input  wire logic [THR_W-1:0] thresh_i,
  output logic                  div_start_o,
  output logic [PROD_W-1:0]     div_value_o,
  input  wire logic             div_done_i,
  input  wire logic [P90K_W-1:0] div_quot_i,
  output logic                  res_valid_o,
  output res_t                  res_o
);

  localparam int unsigned VAW = (VIDEO_DEPTH > 1) ? $clog2(VIDEO_DEPTH) : 1;
  localparam int unsigned VCW = $clog2(VIDEO_DEPTH + 1);
  localparam int unsigned AAW = (AUDIO_DEPTH > 1) ? $clog2(AUDIO_DEPTH) : 1;
  localparam int unsigned ACW = $clog2(AUDIO_DEPTH + 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_LOAD   = 7'b0000010,
    S_DIFF   = 7'b0000100,
    S_DEC    = 7'b0001000,
    S_CONV   = 7'b0010000,
    S_ASTART = 7'b0100000,
    S_SPARE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [PTS_W:0]   vmem [VIDEO_DEPTH];
  logic [PTS_W-1:0] amem [AUDIO_DEPTH];
  logic [PTS_W:0]   vrd_q;
  logic [PTS_W-1:0] ard_q;

  logic [VAW-1:0] vhead_q, vtail_q;
  logic [VCW-1:0] vcnt_q;
  logic [AAW-1:0] ahead_q, atail_q;
  logic [ACW-1:0] acnt_q;

  logic             tvalid_q, aest_q;
  logic [PTS_W-1:0] wa_q, ca_q, now_q, vpts_q;
  logic             vpad_q;
  logic signed [PTS_W:0]   a_q, b_q;
  logic signed [PTS_W+1:0] diff_q;
  logic kind_q, real_q, take_q;

  logic v_push, a_push, v_pop, a_pop;
  logic jump, late, release_ok, more;

  function automatic logic [PROD_W-1:0] times9(input logic [PTS_W-1:0] p);
    return ({4'b0, p} << 3) + {4'b0, p};
  endfunction

  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i;
  assign v_push    = cmd_pop_o && (cmd_i.op == OP_VIDEO);
  assign a_push    = cmd_pop_o && (cmd_i.op == OP_AUDIO);

  assign jump = diff_q > $signed({18'b0, thresh_i});
  assign late = jump || diff_q[PTS_W+1] || (diff_q == '0);
  assign release_ok = !(pacing_en_i && !late) && !(aest_q && acnt_q == '0);
  assign v_pop = (state_q == S_DEC) && release_ok;
  assign a_pop = (state_q == S_ASTART);
  assign more  = (acnt_q != '0) && (ard_q <= vpts_q);

  assign div_start_o = v_pop || a_pop;
  assign div_value_o = a_pop ? times9(ard_q) : times9(vpts_q);

  assign res_valid_o   = (state_q == S_CONV) && div_done_i;
  assign res_o.kind    = kind_q;
  assign res_o.pts_90k = div_quot_i;
  assign res_o.is_real = real_q;
  assign res_o.takeover = take_q;
  assign res_o.last    = !more;

  // queue storage, registered reads at the heads
  always_ff @(posedge clk_i) begin
    if (v_push) vmem[vtail_q] <= {cmd_i.pad, cmd_i.pts};
    if (a_push) amem[atail_q] <= cmd_i.pts;
    vrd_q <= vmem[vhead_q];
    ard_q <= amem[ahead_q];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (cmd_valid_i && cmd_i.op == OP_TICK && vcnt_q != '0) state_d = S_LOAD;
      S_LOAD:   state_d = S_DIFF;
      S_DIFF:   state_d = S_DEC;
      S_DEC:    state_d = release_ok ? S_CONV : S_IDLE;
      S_CONV:   if (div_done_i) state_d = more ? S_ASTART : S_IDLE;
      S_ASTART: state_d = S_CONV;
      default:  state_d = S_IDLE;
    endcase
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) now_q <= cmd_i.now;
    if (state_q == S_LOAD) begin
      vpts_q <= vrd_q[PTS_W-1:0];
      vpad_q <= vrd_q[PTS_W];
      if (!tvalid_q) begin
        a_q <= '0;
        b_q <= '0;
      end else begin
        a_q <= $signed({1'b0, vrd_q[PTS_W-1:0]}) - $signed({1'b0, ca_q});
        b_q <= $signed({1'b0, now_q}) - $signed({1'b0, wa_q});
      end
    end
    if (state_q == S_DIFF) diff_q <= {a_q[PTS_W], a_q} - {b_q[PTS_W], b_q};
    if (v_pop) begin
      kind_q <= 1'b0;
      real_q <= !vpad_q;
      take_q <= 1'b0;
    end else if (a_pop) begin
      kind_q <= 1'b1;
      real_q <= 1'b0;
      take_q <= !aest_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      vhead_q  <= '0;
      vtail_q  <= '0;
      vcnt_q   <= '0;
      ahead_q  <= '0;
      atail_q  <= '0;
      acnt_q   <= '0;
      tvalid_q <= 1'b0;
      aest_q   <= 1'b0;
      wa_q     <= '0;
      ca_q     <= '0;
    end else begin
      state_q <= state_d;
      if (v_push) begin
        vtail_q <= (vtail_q == VAW'(VIDEO_DEPTH - 1)) ? '0 : vtail_q + 1'b1;
        if (vcnt_q == VCW'(VIDEO_DEPTH)) begin
          // full: oldest entry is overwritten
          vhead_q <= (vhead_q == VAW'(VIDEO_DEPTH - 1)) ? '0 : vhead_q + 1'b1;
        end else begin
          vcnt_q <= vcnt_q + 1'b1;
        end
      end
      if (v_pop) begin
        vhead_q <= (vhead_q == VAW'(VIDEO_DEPTH - 1)) ? '0 : vhead_q + 1'b1;
        vcnt_q  <= vcnt_q - 1'b1;
      end
      if (a_push) begin
        atail_q <= (atail_q == AAW'(AUDIO_DEPTH - 1)) ? '0 : atail_q + 1'b1;
        if (acnt_q == ACW'(AUDIO_DEPTH)) begin
          ahead_q <= (ahead_q == AAW'(AUDIO_DEPTH - 1)) ? '0 : ahead_q + 1'b1;
        end else begin
          acnt_q <= acnt_q + 1'b1;
        end
      end
      if (a_pop) begin
        ahead_q <= (ahead_q == AAW'(AUDIO_DEPTH - 1)) ? '0 : ahead_q + 1'b1;
        acnt_q  <= acnt_q - 1'b1;
        aest_q  <= 1'b1;
      end
      if (state_q == S_LOAD && !tvalid_q) begin
        tvalid_q <= 1'b1;
        wa_q     <= now_q;
        ca_q     <= vrd_q[PTS_W-1:0];
      end
      if (state_q == S_DEC && jump) begin
        wa_q <= now_q;
        ca_q <= vpts_q;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/paced_av_mux_scheduler.sv -----
// ----------------------------------------------------------------------------
// paced_av_mux_scheduler
// Paced audio/video release scheduler with 90 kHz timestamp output.
//
//   channel  dir  handshake               payload
//   command  in   start / busy            op_i pts_us_i is_pad_i now_us_i
//   config   in   cfg_valid_i/cfg_ready_o cfg_index_i cfg_data_i
//   result   out  valid_o (one cycle)     kind_o pts_90k_o is_real_o
//                                         audio_takeover_o last_o
//
// A queued command leaves the command queue when the idle engine pops it.
// A tick that releases runs the pacing evaluation (load, difference,
// decision), then converts the video frame and each audio frame with the
// four-step divide by 100. A 2-entry command queue decouples the input.
// Reset leaves both frame queues empty and timing unanchored. Results cannot
// be stalled; busy is high while the command queue is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module paced_av_mux_scheduler import pams_pkg::*; #(
  parameter int unsigned VIDEO_DEPTH = VIDEO_DEPTH_DEF,
  parameter int unsigned AUDIO_DEPTH = AUDIO_DEPTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        op_i,
  input  wire logic [PTS_W-1:0]  pts_us_i,
  input  wire logic              is_pad_i,
  input  wire logic [PTS_W-1:0]  now_us_i,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic              cfg_index_i,
  input  wire logic [THR_W-1:0]  cfg_data_i,
  output logic                   valid_o,
  output logic                   kind_o,
  output logic [P90K_W-1:0]      pts_90k_o,
  output logic                   is_real_o,
  output logic                   audio_takeover_o,
  output logic                   last_o
);

  cmd_t              cmd_in, cmd_q;
  logic              cmd_valid, cmd_pop;
  logic              pacing_q;
  logic [THR_W-1:0]  thresh_q;
  logic              div_start, div_done;
  logic [PROD_W-1:0] div_value;
  logic [P90K_W-1:0] div_quot;
  res_t              res;

  assign cmd_in.op  = op_i;
  assign cmd_in.pts = pts_us_i;
  assign cmd_in.pad = is_pad_i;
  assign cmd_in.now = now_us_i;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pacing_q <= 1'b1;
      thresh_q <= THRESH_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PACING: pacing_q <= cfg_data_i[0];
        REG_THRESH: thresh_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  pams_cmd_queue u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .cmd_i   (cmd_in),
    .full_o  (busy),
    .valid_o (cmd_valid),
    .cmd_o   (cmd_q),
    .pop_i   (cmd_pop)
  );

  pams_engine #(
    .VIDEO_DEPTH (VIDEO_DEPTH),
    .AUDIO_DEPTH (AUDIO_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_q),
    .cmd_pop_o   (cmd_pop),
    .pacing_en_i (pacing_q),
    .thresh_i    (thresh_q),
    .div_start_o (div_start),
    .div_value_o (div_value),
    .div_done_i  (div_done),
    .div_quot_i  (div_quot),
    .res_valid_o (valid_o),
    .res_o       (res)
  );

  pams_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .value_i (div_value),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign kind_o           = res.kind;
  assign pts_90k_o        = res.pts_90k;
  assign is_real_o        = res.is_real;
  assign audio_takeover_o = res.takeover;
  assign last_o           = res.last;

endmodule

`default_nettype wire

// ----- design/pams_checker.sv -----
// ----------------------------------------------------------------------------
// pams_checker
// Port-level checks of the scheduler's result stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pams_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic valid_o,
  input wire logic kind_o,
  input wire logic is_real_o,
  input wire logic audio_takeover_o
);

  // a video result is never marked as the audio takeover
  a_video_no_takeover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !kind_o |-> !audio_takeover_o) else $error("takeover on video");

  // audio results never carry real-content flag
  a_audio_not_real: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && kind_o |-> !is_real_o) else $error("is_real on audio");

  // each result needs a full conversion, so strobes never abut
  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("back-to-back results");

endmodule

bind paced_av_mux_scheduler pams_checker u_pams_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .valid_o          (valid_o),
  .kind_o           (kind_o),
  .is_real_o        (is_real_o),
  .audio_takeover_o (audio_takeover_o)
);

`default_nettype wire
